@@ hw/rtl/m3i_pkg.sv @@
// ----------------------------------------------------------------------------
// m3i_pkg
// shared widths, types and cofactor product tables for the 3x3 inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;
    localparam int CW        = 2 * EW;
    localparam int DETW      = CW + EW + 1;
    localparam int DMW       = DETW - 1;
    localparam int RW        = DMW + 1;
    localparam int NW        = CW + 2 * FRAC_BITS;
    localparam int QW        = 32;
    localparam int NE        = 9;
    localparam int NROW      = 3;
    localparam int NPROD     = 2 * NE;

    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [CW-1:0] t_cof;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    // cofactor k = a[CF_A[2k]]*a[CF_B[2k]] - a[CF_A[2k+1]]*a[CF_B[2k+1]]
    localparam logic [3:0] CF_A [NPROD] = '{
        4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4,
        4'd2, 4'd1, 4'd0, 4'd2, 4'd1, 4'd0,
        4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1
    };
    localparam logic [3:0] CF_B [NPROD] = '{
        4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6,
        4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd7,
        4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3
    };

endpackage

@@ hw/rtl/m3i_if.sv @@
// ----------------------------------------------------------------------------
// m3i_if
// valid/ready channels carrying a matrix beat and an inverse beat
// ----------------------------------------------------------------------------
interface m3i_in_if import m3i_pkg::*;;
    logic  valid;
    logic  ready;
    t_elem a_r0c0;
    t_elem a_r0c1;
    t_elem a_r0c2;
    t_elem a_r1c0;
    t_elem a_r1c1;
    t_elem a_r1c2;
    t_elem a_r2c0;
    t_elem a_r2c1;
    t_elem a_r2c2;

    modport source (
        output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        input  ready
    );
    modport sink (
        input  valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        output ready
    );
endinterface

interface m3i_out_if import m3i_pkg::*;;
    logic  valid;
    logic  ready;
    t_elem inv_r0c0;
    t_elem inv_r0c1;
    t_elem inv_r0c2;
    t_elem inv_r1c0;
    t_elem inv_r1c1;
    t_elem inv_r1c2;
    t_elem inv_r2c0;
    t_elem inv_r2c1;
    t_elem inv_r2c2;
    logic  singular;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular,
        output ready
    );
endinterface

@@ hw/rtl/matrix3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 inverse in signed Q16.16 with exact determinant and singular flag
// ----------------------------------------------------------------------------
// One matrix is accepted every cycle unless the output stalls, and each gives one
// inverse beat through 2 stages of cofactor products, 3 stages for the exact
// determinant, and 34 stages of divider, whose restoring array retires one
// quotient bit per stage over 32 stages and sets the latency. The whole
// pipeline advances together and holds while the output beat waits, so ready
// drops only when the output register is full and not taken.
module matrix3_inverse import m3i_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    m3i_in_if.sink    i_in,
    m3i_out_if.source o_out
);

    logic           w_en;
    t_ctl           w_ctl_in;
    t_ctl           w_ctl_det;
    t_ctl           w_ctl_div;
    t_elem          w_a [NE];
    logic           w_cf_valid;
    t_cof           w_cf_cof [NE];
    t_elem          w_cf_row0 [NROW];
    logic           w_dt_valid;
    t_cof           w_dt_cof [NE];
    logic [DMW-1:0] w_den;
    logic           w_den_neg;
    logic           w_sing;
    logic           w_out_valid;
    t_elem          w_inv [NE];
    logic           w_out_sing;

    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_a = '{i_in.a_r0c0, i_in.a_r0c1, i_in.a_r0c2,
                   i_in.a_r1c0, i_in.a_r1c1, i_in.a_r1c2,
                   i_in.a_r2c0, i_in.a_r2c1, i_in.a_r2c2};

    assign w_ctl_in  = '{en: w_en, valid: i_in.valid};
    assign w_ctl_det = '{en: w_en, valid: w_cf_valid};
    assign w_ctl_div = '{en: w_en, valid: w_dt_valid};

    m3i_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_a     (w_a),
        .o_valid (w_cf_valid),
        .o_cof   (w_cf_cof),
        .o_row0  (w_cf_row0)
    );

    m3i_det u_det (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_det),
        .i_cof     (w_cf_cof),
        .i_row0    (w_cf_row0),
        .o_valid   (w_dt_valid),
        .o_cof     (w_dt_cof),
        .o_den     (w_den),
        .o_den_neg (w_den_neg),
        .o_sing    (w_sing)
    );

    m3i_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_div),
        .i_cof     (w_dt_cof),
        .i_den     (w_den),
        .i_den_neg (w_den_neg),
        .i_sing    (w_sing),
        .o_valid   (w_out_valid),
        .o_inv     (w_inv),
        .o_sing    (w_out_sing)
    );

    // inverse element (r,c) is cofactor (c,r)
    assign o_out.valid    = w_out_valid;
    assign o_out.inv_r0c0 = w_inv[0];
    assign o_out.inv_r0c1 = w_inv[3];
    assign o_out.inv_r0c2 = w_inv[6];
    assign o_out.inv_r1c0 = w_inv[1];
    assign o_out.inv_r1c1 = w_inv[4];
    assign o_out.inv_r1c2 = w_inv[7];
    assign o_out.inv_r2c0 = w_inv[2];
    assign o_out.inv_r2c1 = w_inv[5];
    assign o_out.inv_r2c2 = w_inv[8];
    assign o_out.singular = w_out_sing;

endmodule

@@ hw/rtl/m3i_cofactor.sv @@
// ----------------------------------------------------------------------------
// m3i_cofactor
// two stages: eighteen 32x32 products, then the nine cofactor differences
// ----------------------------------------------------------------------------
module m3i_cofactor import m3i_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_elem i_a [NE],
    output logic  o_valid,
    output t_cof  o_cof [NE],
    output t_elem o_row0 [NROW]
);

    logic [1:0] r_v;
    t_cof       r_prod [NPROD];
    t_elem      r_row0_a [NROW];
    t_cof       r_cof [NE];
    t_elem      r_row0_b [NROW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < NPROD; k++) begin
                r_prod[k] <= CW'(i_a[CF_A[k]]) * CW'(i_a[CF_B[k]]);
            end
            for (int j = 0; j < NROW; j++) begin
                r_row0_a[j] <= i_a[j];
                r_row0_b[j] <= r_row0_a[j];
            end
            for (int k = 0; k < NE; k++) begin
                r_cof[k] <= r_prod[2*k] - r_prod[2*k+1];
            end
        end
    end

    assign o_valid = r_v[1];
    assign o_cof   = r_cof;
    assign o_row0  = r_row0_b;

endmodule

@@ hw/rtl/m3i_det.sv @@
// ----------------------------------------------------------------------------
// m3i_det
// determinant along row 0: split partial products, exact sum, sign/magnitude
// ----------------------------------------------------------------------------
module m3i_det import m3i_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_ctl           i_ctl,
    input  t_cof           i_cof [NE],
    input  t_elem          i_row0 [NROW],
    output logic           o_valid,
    output t_cof           o_cof [NE],
    output logic [DMW-1:0] o_den,
    output logic           o_den_neg,
    output logic           o_sing
);

    logic [2:0]             r_v;
    logic signed [CW:0]     r_pl [NROW];
    logic signed [CW-1:0]   r_ph [NROW];
    t_cof                   r_cof_a [NE];
    t_cof                   r_cof_b [NE];
    t_cof                   r_cof_c [NE];
    logic signed [DETW-1:0] r_det;
    logic signed [DETW-1:0] n_det;
    logic [DMW-1:0]         r_den;
    logic                   r_den_neg;
    logic                   r_sing;
    logic signed [DETW-1:0] w_neg_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[1:0], i_ctl.valid};
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < NROW; j++) begin
            n_det = n_det + (DETW'(r_ph[j]) <<< EW) + DETW'(r_pl[j]);
        end
    end

    assign w_neg_det = -r_det;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int j = 0; j < NROW; j++) begin
                r_pl[j] <= $signed({1'b0, i_cof[j][EW-1:0]}) * (CW+1)'(i_row0[j]);
                r_ph[j] <= CW'($signed(i_cof[j][CW-1:EW])) * CW'(i_row0[j]);
            end
            r_cof_a   <= i_cof;
            r_cof_b   <= r_cof_a;
            r_cof_c   <= r_cof_b;
            r_det     <= n_det;
            r_den     <= r_det[DETW-1] ? w_neg_det[DMW-1:0] : r_det[DMW-1:0];
            r_den_neg <= r_det[DETW-1];
            r_sing    <= (r_det == '0);
        end
    end

    assign o_valid   = r_v[2];
    assign o_cof     = r_cof_c;
    assign o_den     = r_den;
    assign o_den_neg = r_den_neg;
    assign o_sing    = r_sing;

endmodule

@@ hw/rtl/m3i_div.sv @@
// ----------------------------------------------------------------------------
// m3i_div
// nine-lane restoring divider, one quotient bit per stage, then saturation
// ----------------------------------------------------------------------------
module m3i_div import m3i_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_ctl           i_ctl,
    input  t_cof           i_cof [NE],
    input  logic [DMW-1:0] i_den,
    input  logic           i_den_neg,
    input  logic           i_sing,
    output logic           o_valid,
    output t_elem          o_inv [NE],
    output logic           o_sing
);

    logic [QW+1:0]   r_v;
    logic [RW-1:0]   r_rem [QW+1][NE];
    logic [QW-1:0]   r_low [QW+1][NE];
    logic [QW-1:0]   r_q   [QW+1][NE];
    logic            r_big [QW+1][NE];
    logic            r_neg [QW+1][NE];
    logic [DMW-1:0]  r_den [QW+1];
    logic            r_sing [QW+1];
    t_elem           r_inv [NE];
    logic            r_osing;

    logic [RW-1:0]   n_rem [QW+1][NE];
    logic [QW-1:0]   n_low [QW+1][NE];
    logic [QW-1:0]   n_q   [QW+1][NE];
    logic [CW-1:0]   w_mag [NE];
    logic [NW-1:0]   w_num [NE];
    logic [RW-1:0]   w_shift;
    logic            w_ge;
    logic            w_nz;

    function automatic logic [QW-1:0] f_sat(input logic [QW-1:0] q,
                                            input logic big, input logic neg);
        logic [QW-1:0] res;
        if (!neg) begin
            res = (big || q > SAT_POS) ? SAT_POS : q;
        end else begin
            res = (big || q > SAT_NEG) ? SAT_NEG : (~q + QW'(1));
        end
        return res;
    endfunction

    always_comb begin
        w_shift = '0;
        w_ge    = 1'b0;
        for (int l = 0; l < NE; l++) begin
            w_mag[l]    = i_cof[l][CW-1] ? (~i_cof[l] + CW'(1)) : i_cof[l];
            w_num[l]    = NW'(w_mag[l]) << (2 * FRAC_BITS);
            n_rem[0][l] = RW'(w_num[l][NW-1:QW]);
            n_low[0][l] = w_num[l][QW-1:0];
            n_q[0][l]   = '0;
        end
        for (int s = 1; s <= QW; s++) begin
            for (int l = 0; l < NE; l++) begin
                w_shift     = {r_rem[s-1][l][RW-2:0], r_low[s-1][l][QW-1]};
                w_ge        = (w_shift >= RW'(r_den[s-1]));
                n_rem[s][l] = w_ge ? (w_shift - RW'(r_den[s-1])) : w_shift;
                n_low[s][l] = {r_low[s-1][l][QW-2:0], 1'b0};
                n_q[s][l]   = {r_q[s-1][l][QW-2:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[QW:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_den[0]  <= i_den;
            r_sing[0] <= i_sing;
            for (int l = 0; l < NE; l++) begin
                r_big[0][l] <= (n_rem[0][l] >= RW'(i_den));
                r_neg[0][l] <= i_cof[l][CW-1] ^ i_den_neg;
            end
            for (int s = 1; s <= QW; s++) begin
                r_den[s]  <= r_den[s-1];
                r_sing[s] <= r_sing[s-1];
                for (int l = 0; l < NE; l++) begin
                    r_big[s][l] <= r_big[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
            end
            for (int s = 0; s <= QW; s++) begin
                for (int l = 0; l < NE; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_low[s][l] <= n_low[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
            for (int l = 0; l < NE; l++) begin
                r_inv[l] <= r_sing[QW] ? '0 :
                            f_sat(r_q[QW][l], r_big[QW][l], r_neg[QW][l]);
            end
            r_osing <= r_sing[QW];
        end
    end

    always_comb begin
        w_nz = 1'b0;
        for (int l = 0; l < NE; l++) begin
            w_nz = w_nz | (r_inv[l] != '0);
        end
    end

    assign o_valid = r_v[QW+1];
    assign o_inv   = r_inv;
    assign o_sing  = r_osing;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW+1] && r_osing |-> !w_nz)
        else $error("singular beat with nonzero inverse");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && i_ctl.valid |=> r_v[0])
        else $error("accepted beat lost at divider entry");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> $stable(r_v))
        else $error("pipeline moved while stalled");

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !r_sing[0] |-> r_den[0] != '0)
        else $error("zero divisor on nonsingular beat");

endmodule

@@ bench/tb_matrix3_inverse.sv @@
// ----------------------------------------------------------------------------
// tb_matrix3_inverse
// self-checking bench for the 3x3 fixed-point inverse: directed and random
// matrices go in with bursty valid, results come out under a stalling ready
// and are checked field by field against an exact in-bench predictor
// ----------------------------------------------------------------------------
module tb_matrix3_inverse;
    import m3i_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] el [9];
        logic               singular;
    } t_inv_beat;

    int unsigned n_errors;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // quotient of cofactor * 2^(2*FRAC_BITS) by det, toward zero, saturated
    function automatic logic [31:0] sat_quotient(input logic signed [63:0] cof,
                                                 input logic signed [127:0] det);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = 128'(cof) <<< (2 * FRAC_BITS);
        q   = num / det;
        if (q > 128'sh7FFFFFFF)
            return SAT_POS;
        if (q < -128'sh80000000)
            return SAT_NEG;
        return q[31:0];
    endfunction

    function automatic t_inv_beat predict_inverse(input logic signed [31:0] a [9]);
        t_inv_beat           r;
        logic signed [63:0]  m [9];
        logic signed [63:0]  c [3][3];
        logic signed [127:0] det;
        foreach (a[k]) m[k] = a[k];
        c[0][0] = m[4]*m[8] - m[5]*m[7];
        c[0][1] = m[5]*m[6] - m[3]*m[8];
        c[0][2] = m[3]*m[7] - m[4]*m[6];
        c[1][0] = m[2]*m[7] - m[1]*m[8];
        c[1][1] = m[0]*m[8] - m[2]*m[6];
        c[1][2] = m[1]*m[6] - m[0]*m[7];
        c[2][0] = m[1]*m[5] - m[2]*m[4];
        c[2][1] = m[2]*m[3] - m[0]*m[5];
        c[2][2] = m[0]*m[4] - m[1]*m[3];
        det = 128'(c[0][0]) * 128'(m[0]) + 128'(c[0][1]) * 128'(m[1])
            + 128'(c[0][2]) * 128'(m[2]);
        r.singular = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r.el[i*3+j] = r.singular ? 32'sd0 : sat_quotient(c[j][i], det);
        return r;
    endfunction

    class inverse_scoreboard;
        t_inv_beat   pending [$];
        int unsigned n_in, n_out, n_singular;

        function void note_matrix(input logic signed [31:0] a [9]);
            pending.push_back(predict_inverse(a));
            n_in++;
        endfunction

        task check_result(input t_inv_beat got);
            t_inv_beat want;
            n_out++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.singular !== want.singular)
                report_mismatch("singular", got.singular, want.singular);
            if (want.singular)
                n_singular++;
            for (int k = 0; k < 9; k++)
                if (got.el[k] !== want.el[k])
                    report_mismatch($sformatf("inv[%0d][%0d] of beat %0d", k / 3, k % 3,
                                    n_out), got.el[k], want.el[k]);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    m3i_in_if  mat_if ();
    m3i_out_if inv_if ();

    matrix3_inverse uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (mat_if.sink),
        .o_out   (inv_if.source)
    );

    inverse_scoreboard sb = new();

    bit hold_ready;
    bit stall_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        mat_if.valid  = 1'b0;
        mat_if.a_r0c0 = '0; mat_if.a_r0c1 = '0; mat_if.a_r0c2 = '0;
        mat_if.a_r1c0 = '0; mat_if.a_r1c1 = '0; mat_if.a_r1c2 = '0;
        mat_if.a_r2c0 = '0; mat_if.a_r2c1 = '0; mat_if.a_r2c2 = '0;
        inv_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sink side: stall pattern plus a long hold-off on request
    initial begin
        int unsigned phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_ready)
                inv_if.ready <= 1'b0;
            else if (stall_burst)
                inv_if.ready <= ($urandom_range(0, 3) == 0);
            else if (phase % 300 < 100)
                inv_if.ready <= 1'b1;
            else
                inv_if.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_inv_beat got;
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            got.el[0] = inv_if.inv_r0c0; got.el[1] = inv_if.inv_r0c1;
            got.el[2] = inv_if.inv_r0c2; got.el[3] = inv_if.inv_r1c0;
            got.el[4] = inv_if.inv_r1c1; got.el[5] = inv_if.inv_r1c2;
            got.el[6] = inv_if.inv_r2c0; got.el[7] = inv_if.inv_r2c1;
            got.el[8] = inv_if.inv_r2c2; got.singular = inv_if.singular;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && mat_if.valid && mat_if.ready) begin
            logic signed [31:0] a [9];
            a[0] = mat_if.a_r0c0; a[1] = mat_if.a_r0c1; a[2] = mat_if.a_r0c2;
            a[3] = mat_if.a_r1c0; a[4] = mat_if.a_r1c1; a[5] = mat_if.a_r1c2;
            a[6] = mat_if.a_r2c0; a[7] = mat_if.a_r2c1; a[8] = mat_if.a_r2c2;
            sb.note_matrix(a);
        end

    // drive one matrix beat and hold it until taken; valid stays high if
    // another beat follows at once
    task automatic send_matrix(input logic signed [31:0] a [9], input bit keep);
        mat_if.valid  <= 1'b1;
        mat_if.a_r0c0 <= a[0]; mat_if.a_r0c1 <= a[1]; mat_if.a_r0c2 <= a[2];
        mat_if.a_r1c0 <= a[3]; mat_if.a_r1c1 <= a[4]; mat_if.a_r1c2 <= a[5];
        mat_if.a_r2c0 <= a[6]; mat_if.a_r2c1 <= a[7]; mat_if.a_r2c2 <= a[8];
        do @(posedge i_clk); while (!mat_if.ready);
        if (!keep)
            mat_if.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3, 4:    return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            5, 6:    return $signed($urandom_range(0, 32'h7FF)) - 32'sh400;
            default: return $urandom;
        endcase
    endfunction

    task automatic make_matrix(output logic signed [31:0] a [9]);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        foreach (a[k]) a[k] = rand_elem();
        if (kind == 0) begin
            // rows dependent
            for (int k = 0; k < 3; k++) a[6+k] = a[k];
        end else if (kind == 1) begin
            foreach (a[k]) a[k] = (k % 4 == 0) ? $signed($urandom_range(1, 32'h40000)) : 0;
            if ($urandom_range(0, 1)) a[4] = -a[4];
        end else if (kind == 2) begin
            // tiny determinant pushes the quotients into saturation
            foreach (a[k]) a[k] = $signed($urandom_range(0, 6)) - 3;
        end
    endtask

    initial begin
        logic signed [31:0] a [9];
        int unsigned burst;
        int unsigned gap;
        hold_ready  = 1'b0;
        stall_burst = 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);

        // directed matrices
        foreach (a[k]) a[k] = (k % 4 == 0) ? 32'sh10000 : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? 32'sh7FFFFFFF : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? 32'sh80000000 : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? 32'sd1 : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? -32'sd1 : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = 32'sh7FFFFFFF;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = 32'sh80000000;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = -32'sd1;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? 32'sd3 : 0;
        send_matrix(a, 1);
        foreach (a[k]) a[k] = (k % 4 == 0) ? -32'sd3 : 0;
        send_matrix(a, 1);
        a = '{32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh30000, 32'sh10000,
              0, 32'sh10000, 32'sh40000};
        send_matrix(a, 1);
        a = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
        send_matrix(a, 1);
        a = '{32'sh55555555, -32'sh55555556, 32'sh0F0F0F0F, -32'sh0F0F0F10, 32'sh33333333,
              -32'sh33333334, 32'sh00FF00FF, -32'sh00FF0100, 32'sh12345678};
        send_matrix(a, 0);

        // sender pauses until the pipe drains
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // long receiver hold-off while the sender keeps pushing
        hold_ready = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_ready = 1'b0;
            end
            for (int n = 0; n < 60; n++) begin
                make_matrix(a);
                send_matrix(a, n != 59);
            end
        join
        @(posedge i_clk);

        for (int n = 0; n < 1250; ) begin
            stall_burst = (n > 600 && n < 750);
            burst = $urandom_range(1, 40);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 1250; b++, n++) begin
                make_matrix(a);
                send_matrix(a, (b != burst - 1 || gap == 0) && n != 1249);
            end
            repeat (gap) @(posedge i_clk);
        end
        stall_burst = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d matrices, checked %0d inverse beats, %0d singular",
                 sb.n_in, sb.n_out, sb.n_singular);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_if.sv
hw/rtl/m3i_cofactor.sv
hw/rtl/m3i_det.sv
hw/rtl/m3i_div.sv
hw/rtl/matrix3_inverse.sv
bench/tb_matrix3_inverse.sv
